### hw/rtl/gwns_pkg.sv
// Shared constants and types for the Gaussian neighbour smoother.
// No dependencies; imported by the front, back and top modules.
package gwns_pkg;

  localparam int CFG_W        = 11;
  localparam int CFG_IDX_W    = 2;
  localparam int HW           = 11;    // row counter / height width
  localparam int RW           = 3;     // effective radius width
  localparam int HEIGHT_LIMIT = 1024;
  localparam int QDEPTH       = 4;
  localparam int NTAPS        = 13;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd2;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Q0.16 weight of the distance-one neighbours
  localparam logic [13:0] W1_R1 = 14'd16383;
  localparam logic [13:0] W1_RN = 14'd16381;

  typedef logic [23:0] pixel_t;

endpackage

### hw/rtl/gwns_if.sv
// Valid/ready channel interfaces for pixel requests and results.
// No dependencies.
interface gwns_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  modport source (output valid, cmd, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, cmd, red_in, green_in, blue_in, output ready);
endinterface

interface gwns_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       frame_last;
  modport source (output valid, red_out, green_out, blue_out, frame_last, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, frame_last, output ready);
endinterface

### hw/rtl/gwns_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gwns_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/gwns_queue.sv
// Short FIFO of emit jobs between front and back.
// Depends on nothing but its parameters.
module gwns_queue #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             full,
  output logic             empty
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [IW-1:0]    wptr_r, rptr_r;
  logic [CW-1:0]    count_r, count_nxt;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop)) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("pop from empty queue");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count lost a push");
`endif

endmodule

### hw/rtl/gwns_front.sv
// Front end: accepts requests, writes the pixel ring, tracks pending pixels and
// output position, and queues one emit job per result. Uses gwns_pkg, gwns_if.
module gwns_front
  import gwns_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 3,
  parameter int RING       = 6151,
  parameter int AW         = 13,
  parameter int PW         = 13,
  parameter int WW         = 11,
  parameter int TW         = 27
) (
  input  logic                 clk,
  input  logic                 rst_n,
  gwns_in_if.sink              in_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 q_full,
  output logic                 q_push,
  output logic [TW-1:0]        q_data,
  output logic                 wr_en,
  output logic [AW-1:0]        wr_addr,
  output pixel_t               wr_data
);

  typedef struct packed {
    logic [AW-1:0] centre;
    logic [WW-1:0] wid;
    logic          smooth;
    logic          r1;
    logic          last;
  } job_t;

  logic [CFG_W-1:0] cfg_w_r, cfg_h_r;
  logic [1:0]       cfg_r_r;
  logic [AW-1:0]    wp_r;
  logic [PW-1:0]    pend_r, pend_nxt, pend_inc, lag;
  logic [WW-1:0]    col_r, col_nxt, w;
  logic [HW-1:0]    row_r, row_nxt, h;
  logic [RW-1:0]    r;
  logic             accept, is_data, do_emit, interior, last;
  job_t             job;

  always_comb begin
    if (cfg_w_r == '0) begin
      w = WW'(1);
    end else if (int'(cfg_w_r) > MAX_WIDTH) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(cfg_w_r);
    end
    if (cfg_h_r == '0) begin
      h = HW'(1);
    end else if (int'(cfg_h_r) > HEIGHT_LIMIT) begin
      h = HW'(HEIGHT_LIMIT);
    end else begin
      h = HW'(cfg_h_r);
    end
    if (cfg_r_r == '0) begin
      r = RW'(1);
    end else if (int'(cfg_r_r) > MAX_RADIUS) begin
      r = RW'(MAX_RADIUS);
    end else begin
      r = RW'(cfg_r_r);
    end
  end

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_data     = (in_ch.cmd == CMD_PIXEL);

  assign pend_inc = (int'(pend_r) < RING) ? pend_r + 1'b1 : pend_r;
  assign lag      = PW'(PW'(r) * PW'(w)) + PW'(r);
  assign do_emit  = accept && (is_data ? (pend_inc > lag) : (pend_r != '0));

  assign interior = (int'(col_r) >= int'(r)) && (int'(col_r) + int'(r) <= int'(w) - 1)
                 && (int'(row_r) >= int'(r)) && (int'(row_r) + int'(r) <= int'(h) - 1);
  assign last     = (col_r == w - 1'b1) && (row_r == h - 1'b1);

  always_comb begin
    job.centre = is_data ? wp_r - AW'(pend_inc - 1'b1) : wp_r - AW'(pend_r);
    job.wid    = w;
    job.smooth = is_data && interior;
    job.r1     = (r == RW'(1));
    job.last   = last;
  end

  assign q_push  = do_emit;
  assign q_data  = job;
  assign wr_en   = accept && is_data;
  assign wr_addr = wp_r;
  assign wr_data = {in_ch.red_in, in_ch.green_in, in_ch.blue_in};

  always_comb begin
    if (is_data) begin
      pend_nxt = do_emit ? pend_inc - 1'b1 : pend_inc;
    end else begin
      pend_nxt = do_emit ? pend_r - 1'b1 : pend_r;
    end
    col_nxt = col_r;
    row_nxt = row_r;
    if (int'(col_r) + 1 >= int'(w)) begin
      col_nxt = '0;
      row_nxt = (int'(row_r) + 1 >= int'(h)) ? '0 : row_r + 1'b1;
    end else begin
      col_nxt = col_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r <= CFG_W'(1024);
      cfg_h_r <= CFG_W'(1024);
      cfg_r_r <= 2'd1;
      wp_r    <= '0;
      pend_r  <= '0;
      col_r   <= '0;
      row_r   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_WIDTH:  cfg_w_r <= cfg_wdata;
          REG_HEIGHT: cfg_h_r <= cfg_wdata;
          REG_RADIUS: cfg_r_r <= cfg_wdata[1:0];
          default: ;
        endcase
      end
      if (accept) begin
        pend_r <= pend_nxt;
        if (is_data) begin
          wp_r <= wp_r + 1'b1;
        end
      end
      if (do_emit) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

endmodule

### hw/rtl/gwns_back.sv
// Back end: reads the 13 window taps from replicated ring RAMs, sums the
// distance classes and applies the Q0.16 weights. Uses gwns_pkg, gwns_ram, gwns_if.
module gwns_back
  import gwns_pkg::*;
#(
  parameter int AW = 13,
  parameter int WW = 11,
  parameter int TW = 27
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  logic [TW-1:0] q_head,
  output logic          q_pop,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  pixel_t        wr_data,
  gwns_out_if.source    out_ch
);

  typedef struct packed {
    logic [AW-1:0] centre;
    logic [WW-1:0] wid;
    logic          smooth;
    logic          r1;
    logic          last;
  } job_t;

  job_t          head, s1_job_r;
  logic          adv, s1_v_r, s2_v_r, out_valid_r;
  logic [AW-1:0] c, wa, wa2;
  logic [AW-1:0] taddr [NTAPS];
  pixel_t        tdata [NTAPS];

  logic [9:0]    sum1 [3];
  logic [10:0]   sum2 [3];
  logic [9:0]    s2_sum1_r [3];
  logic [10:0]   s2_sum2_r [3];
  pixel_t        s2_pix_r;
  logic          s2_smooth_r, s2_r1_r, s2_last_r;
  logic [7:0]    res [3];
  logic [24:0]   acc [3];
  logic [13:0]   w1;
  logic [7:0]    red_r, green_r, blue_r;
  logic          last_r;

  assign head  = q_head;
  assign adv   = !out_valid_r || out_ch.ready;
  assign q_pop = adv && !q_empty;

  assign c   = head.centre;
  assign wa  = AW'(head.wid);
  assign wa2 = AW'({head.wid, 1'b0});

  // tap 0 centre, 1..4 distance one, 5..8 straight distance two, 9..12 diagonals
  always_comb begin
    taddr[0]  = c;
    taddr[1]  = c - 1'b1;
    taddr[2]  = c + 1'b1;
    taddr[3]  = c - wa;
    taddr[4]  = c + wa;
    taddr[5]  = c - AW'(2);
    taddr[6]  = c + AW'(2);
    taddr[7]  = c - wa2;
    taddr[8]  = c + wa2;
    taddr[9]  = c - wa - 1'b1;
    taddr[10] = c - wa + 1'b1;
    taddr[11] = c + wa - 1'b1;
    taddr[12] = c + wa + 1'b1;
  end

  for (genvar t = 0; t < NTAPS; t++) begin : g_tap
    gwns_ram #(.WIDTH(24), .DEPTH(2 ** AW)) u_ram (
      .clk   (clk),
      .we    (wr_en),
      .waddr (wr_addr),
      .wdata (wr_data),
      .re    (adv),
      .raddr (taddr[t]),
      .rdata (tdata[t])
    );
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum1[ch] = 10'(tdata[1][8*(2-ch) +: 8]) + 10'(tdata[2][8*(2-ch) +: 8])
               + 10'(tdata[3][8*(2-ch) +: 8]) + 10'(tdata[4][8*(2-ch) +: 8]);
      sum2[ch] = 11'(tdata[9][8*(2-ch) +: 8]) + 11'(tdata[10][8*(2-ch) +: 8])
               + 11'(tdata[11][8*(2-ch) +: 8]) + 11'(tdata[12][8*(2-ch) +: 8]);
      // straight distance-two taps lie outside the 3x3 window
      if (!s1_job_r.r1) begin
        sum2[ch] = sum2[ch] + 11'(tdata[5][8*(2-ch) +: 8]) + 11'(tdata[6][8*(2-ch) +: 8])
                 + 11'(tdata[7][8*(2-ch) +: 8]) + 11'(tdata[8][8*(2-ch) +: 8]);
      end
    end
  end

  assign w1 = s2_r1_r ? W1_R1 : W1_RN;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      acc[ch] = 25'(w1) * 25'(s2_sum1_r[ch]) + 25'(s2_sum2_r[ch]);
      res[ch] = s2_smooth_r ? acc[ch][23:16] : s2_pix_r[8*(2-ch) +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_job_r    <= head;
      s2_sum1_r   <= sum1;
      s2_sum2_r   <= sum2;
      s2_pix_r    <= tdata[0];
      s2_smooth_r <= s1_job_r.smooth;
      s2_r1_r     <= s1_job_r.r1;
      s2_last_r   <= s1_job_r.last;
      red_r       <= res[0];
      green_r     <= res[1];
      blue_r      <= res[2];
      last_r      <= s2_last_r;
    end
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_v_r      <= q_pop;
      s2_v_r      <= s1_v_r;
      out_valid_r <= s2_v_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.red_out    = red_r;
  assign out_ch.green_out  = green_r;
  assign out_ch.blue_out   = blue_r;
  assign out_ch.frame_last = last_r;

`ifndef NO_ASSERTIONS
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (s1_v_r == $past(s1_v_r) && s2_v_r == $past(s2_v_r)))
    else $error("pipeline moved while output stalled");
  a_no_pop_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |-> !q_pop) else $error("job popped while stalled");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s2_v_r) |=> out_valid_r) else $error("stage two result dropped");
`endif

endmodule

### hw/rtl/gaussian_weighted_neighbour_smoother.sv
// A released result passes the job queue, the registered RAM read, the stage-two sums and the output register.
// Throughput: one request per cycle while the job queue is not full; the back pipeline stalls only on output ready.
// The 13 window taps come from 13 replicated ring RAMs, one read port each.
// Reset (rst_n, synchronous): clears pointers, counters, pending count and valids;
// config returns to 1024 x 1024, radius 1. The ring RAM is not cleared.
module gaussian_weighted_neighbour_smoother
  import gwns_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  gwns_in_if.sink              in_ch,
  gwns_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int RING = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1;
  localparam int AW   = $clog2(RING + 16);
  localparam int PW   = $clog2(RING + 1);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int TW   = AW + WW + 3;

  logic          q_push, q_pop, q_full, q_empty;
  logic [TW-1:0] q_data, q_head;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  pixel_t        wr_data;

  gwns_front #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_RADIUS(MAX_RADIUS), .RING(RING),
    .AW(AW), .PW(PW), .WW(WW), .TW(TW)
  ) u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .q_full(q_full), .q_push(q_push), .q_data(q_data),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
  );

  gwns_queue #(.WIDTH(TW), .DEPTH(QDEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(q_data),
    .pop(q_pop), .head(q_head), .full(q_full), .empty(q_empty)
  );

  gwns_back #(.AW(AW), .WW(WW), .TW(TW)) u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_head(q_head), .q_pop(q_pop),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data), .out_ch(out_ch)
  );

endmodule
